// ===== sv/binomial_coefficient_mod_prime_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binomial coefficient block
// Shared assertion helpers with clock and reset implied.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_COEFFICIENT_MOD_PRIME_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MOD_PRIME_MACROS_SVH
`define BCM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/bcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient package
// Widths and constants shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package bcm_pkg;
  localparam int unsigned MOD_W     = 31;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned MUL_CNT_W = 5;
  localparam logic [MOD_W-1:0] MOD_RESET = 31'h7FFF_FFFF;
  typedef logic [MOD_W-1:0] mod_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef struct packed {
    logic start;
    mod_t a;
    mod_t b;
  } mul_req_t;
endpackage
`default_nettype wire

// ===== sv/bcm_in_if.sv =====
// ----------------------------------------------------------------------------
// Query channel
// Valid/ready channel carrying n and k.
// ----------------------------------------------------------------------------
`default_nettype none
interface bcm_in_if;
  logic                valid;
  logic                ready;
  bcm_pkg::idx_t       n_total;
  bcm_pkg::idx_t       k_choose;
  modport source (output valid, n_total, k_choose, input ready);
  modport sink   (input valid, n_total, k_choose, output ready);
endinterface
`default_nettype wire

// ===== sv/bcm_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the coefficient and the error flag.
// ----------------------------------------------------------------------------
`default_nettype none
interface bcm_out_if;
  logic                valid;
  logic                ready;
  bcm_pkg::mod_t       coefficient;
  logic                bad_args;
  modport source (output valid, coefficient, bad_args, input ready);
  modport sink   (input valid, coefficient, bad_args, output ready);
endinterface
`default_nettype wire

// ===== sv/bcm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bcm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/bcm_mulmod.sv =====
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Horner form, one bit of a per cycle: acc = 2*acc + (top bit of a ? b : 0), each reduced mod p.
// ----------------------------------------------------------------------------
`default_nettype none
module bcm_mulmod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bcm_pkg::mul_req_t req,
  input  wire bcm_pkg::mod_t     p,
  output logic                   done,
  output bcm_pkg::mod_t          prod
);
  import bcm_pkg::*;
  logic                 busy_r, busy_nxt;
  logic [MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  mod_t                 a_r, a_nxt;
  mod_t                 b_r, b_nxt;
  mod_t                 acc_r, acc_nxt;
  logic                 done_r, done_nxt;
  logic [MOD_W:0]       dbl, dsub, add, asub;
  mod_t                 dred;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = dbl - {1'b0, p};
    dred = dsub[MOD_W] ? dbl[MOD_W-1:0] : dsub[MOD_W-1:0];
    add  = {1'b0, dred} + (a_r[MOD_W-1] ? {1'b0, b_r} : '0);
    asub = add - {1'b0, p};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = req.a;
      b_nxt    = req.b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = asub[MOD_W] ? add[MOD_W-1:0] : asub[MOD_W-1:0];
      a_nxt   = a_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MOD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule
`default_nettype wire

// ===== sv/binomial_coefficient_mod_prime.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient modulo a prime
// C(n,k) mod P from a factorial table extended on demand and Fermat inverses.
// ----------------------------------------------------------------------------
// Usage: queries (n, k) arrive on the in_ channel, one word per query; each
// gives one result word (coefficient, bad_args) on the out_ channel. The
// prime P is written through cfg_we/cfg_wdata while idle; a write resets the
// factorial table to its single entry 0! = 1.
// Every modular multiply is bit-serial over the 31 bits of its multiplier.
// A query costs one multiply per new table entry plus up to 2 x 62
// multiplies for the two inverses (each with its final product), fewer
// for small P.
// Bad arguments or P below two are answered straight from the check state.
// One query is worked on at a time; in_ready is high while idle, also when a
// result still waits in its output register while out_ready is low. A
// finished query holds until that register is free.
// Reset (rst_n low, synchronous) sets P to 2^31-1 and the table to one entry.
// ----------------------------------------------------------------------------
`default_nettype none
`include "binomial_coefficient_mod_prime_macros.svh"
module binomial_coefficient_mod_prime (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cfg_we,
  input  wire bcm_pkg::mod_t cfg_wdata,
  bcm_in_if.sink         in_ch,
  bcm_out_if.source      out_ch
);
  import bcm_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_EXT_R = 4'd2;
  localparam logic [3:0] S_EXT_M = 4'd3;
  localparam logic [3:0] S_LD_R  = 4'd4;
  localparam logic [3:0] S_LD_W  = 4'd5;
  localparam logic [3:0] S_POW   = 4'd6;
  localparam logic [3:0] S_POW_M = 4'd7;
  localparam logic [3:0] S_FIN_M = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]      st_r, st_nxt;
  mod_t            p_r, p_nxt;
  logic [CNT_W-1:0] built_r, built_nxt;
  idx_t            n_r, n_nxt, k_r, k_nxt;
  logic [1:0]      phase_r, phase_nxt;
  mod_t            res_r, res_nxt;
  mod_t            acc_r, acc_nxt;
  mod_t            sq_r, sq_nxt;
  mod_t            exp_r, exp_nxt;
  logic            sqstep_r, sqstep_nxt;
  logic            ovalid_r, ovalid_nxt;
  mod_t            ocoef_r, ocoef_nxt;
  logic            obad_r, obad_nxt;
  logic            rd0_r;

  logic            ram_we;
  idx_t            ram_waddr, ram_raddr;
  mod_t            ram_wdata, ram_rdata;
  mod_t            fact_rd;
  mul_req_t        mreq;
  logic            mdone;
  mod_t            mprod;
  mod_t            i_mod;

  bcm_ram #(.WIDTH(MOD_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  bcm_mulmod u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .p(p_r), .done(mdone), .prod(mprod)
  );

  // i need not be below p: it is the serial operand, reduced by the multiplier
  assign i_mod = MOD_W'(built_r);

  // entry 0 is never stored: 0! reads as one
  assign fact_rd = rd0_r ? MOD_W'(1) : ram_rdata;

  always_comb begin
    st_nxt     = st_r;
    p_nxt      = p_r;
    built_nxt  = built_r;
    n_nxt      = n_r;
    k_nxt      = k_r;
    phase_nxt  = phase_r;
    res_nxt    = res_r;
    acc_nxt    = acc_r;
    sq_nxt     = sq_r;
    exp_nxt    = exp_r;
    sqstep_nxt = sqstep_r;
    ovalid_nxt = ovalid_r;
    ocoef_nxt  = ocoef_r;
    obad_nxt   = obad_r;
    ram_we     = 1'b0;
    ram_waddr  = built_r[IDX_W-1:0];
    ram_wdata  = mprod;
    ram_raddr  = n_r;
    mreq       = '{start: 1'b0, a: '0, b: '0};
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    if (cfg_we) begin
      p_nxt     = cfg_wdata;
      built_nxt = CNT_W'(1);
    end
    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          n_nxt  = in_ch.n_total;
          k_nxt  = in_ch.k_choose;
          st_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (k_r > n_r || p_r < MOD_W'(2)) begin
          if (!ovalid_r) begin
            ovalid_nxt = 1'b1;
            ocoef_nxt  = '0;
            obad_nxt   = k_r > n_r;
            st_nxt     = S_IDLE;
          end
        end else if (built_r <= CNT_W'(n_r)) begin
          ram_raddr = IDX_W'(built_r - 1'b1);
          st_nxt    = S_EXT_R;
        end else begin
          ram_raddr = n_r;
          phase_nxt = 2'd0;
          st_nxt    = S_LD_R;
        end
      end
      S_EXT_R: begin
        mreq   = '{start: 1'b1, a: i_mod, b: fact_rd};
        st_nxt = S_EXT_M;
      end
      S_EXT_M: begin
        if (mdone) begin
          ram_we    = 1'b1;
          built_nxt = built_r + 1'b1;
          st_nxt    = S_CHECK;
        end
      end
      S_LD_R: begin
        st_nxt = S_LD_W;
      end
      S_LD_W: begin
        unique case (phase_r)
          2'd0: begin
            res_nxt   = fact_rd;
            ram_raddr = k_r;
            phase_nxt = 2'd1;
            st_nxt    = S_LD_R;
          end
          default: begin
            acc_nxt    = MOD_W'(1);
            sq_nxt     = fact_rd;
            exp_nxt    = p_r - MOD_W'(2);
            sqstep_nxt = 1'b0;
            st_nxt     = S_POW;
          end
        endcase
        if (phase_r == 2'd0) ram_raddr = k_r;
      end
      S_POW: begin
        if (exp_r == '0) begin
          mreq   = '{start: 1'b1, a: res_r, b: acc_r};
          st_nxt = S_FIN_M;
        end else if (!sqstep_r && exp_r[0]) begin
          mreq   = '{start: 1'b1, a: acc_r, b: sq_r};
          st_nxt = S_POW_M;
        end else begin
          mreq   = '{start: 1'b1, a: sq_r, b: sq_r};
          st_nxt = S_POW_M;
        end
      end
      S_POW_M: begin
        if (mdone) begin
          if (!sqstep_r && exp_r[0]) begin
            acc_nxt    = mprod;
            sqstep_nxt = 1'b1;
          end else begin
            sq_nxt     = mprod;
            exp_nxt    = exp_r >> 1;
            sqstep_nxt = 1'b0;
          end
          st_nxt = S_POW;
        end
      end
      S_FIN_M: begin
        if (mdone) begin
          res_nxt = mprod;
          if (phase_r == 2'd1) begin
            phase_nxt = 2'd2;
            ram_raddr = n_r - k_r;
            st_nxt    = S_LD_R;
          end else begin
            st_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          ocoef_nxt  = res_r;
          obad_nxt   = 1'b0;
          st_nxt     = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_LD_R) begin
      ram_raddr = (phase_r == 2'd0) ? n_r : (phase_r == 2'd1) ? k_r : n_r - k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      p_r      <= MOD_RESET;
      built_r  <= CNT_W'(1);
      ovalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      p_r      <= p_nxt;
      built_r  <= built_nxt;
      ovalid_r <= ovalid_nxt;
    end
    n_r      <= n_nxt;
    k_r      <= k_nxt;
    phase_r  <= phase_nxt;
    res_r    <= res_nxt;
    acc_r    <= acc_nxt;
    sq_r     <= sq_nxt;
    exp_r    <= exp_nxt;
    sqstep_r <= sqstep_nxt;
    ocoef_r  <= ocoef_nxt;
    obad_r   <= obad_nxt;
    rd0_r    <= (ram_raddr == '0);
  end

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = ovalid_r;
  assign out_ch.coefficient = ocoef_r;
  assign out_ch.bad_args    = obad_r;

  `BCM_ASSERT_IMPL(a_bad_zero, ovalid_r && obad_r, ocoef_r == '0)
  `BCM_ASSERT_NEXT(a_built_cap, 1'b1, built_r <= CNT_W'(DEPTH))
  `BCM_ASSERT_IMPL(a_res_lt_p, ovalid_r && !obad_r && p_r >= MOD_W'(2), ocoef_r < p_r)
  `BCM_ASSERT_NEXT(a_hold, ovalid_r && !out_ch.ready, ovalid_r && $stable(ocoef_r))
endmodule
`default_nettype wire

// ===== verif/tb_binomial_coefficient_mod_prime.sv =====
// ----------------------------------------------------------------------------
// Binomial coefficient block testbench
// Drives (n, k) queries over several moduli, predicts C(n,k) mod P with a
// factorial table of its own, and checks every result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_binomial_coefficient_mod_prime;
  import bcm_pkg::*;

  typedef struct packed {
    idx_t n;
    idx_t k;
  } query_t;

  typedef struct packed {
    mod_t coef;
    logic bad;
  } answer_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  mod_t  cfg_wdata = '0;

  bcm_in_if  in_ch ();
  bcm_out_if out_ch ();

  binomial_coefficient_mod_prime u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always #10 clk = ~clk;

  query_t  pending_q[$];
  answer_t coef_q[$];
  mod_t    prime;
  mod_t    fact_tab[DEPTH];
  int      fact_cnt;
  int      errors = 0;
  int      drv_gap = 0;
  int      mon_gap = 0;

  function automatic mod_t mulp(mod_t a, mod_t b);
    return mod_t'((64'(a) * 64'(b)) % 64'(prime));
  endfunction

  function automatic mod_t powp(mod_t b, mod_t e);
    mod_t acc;
    mod_t sq;
    acc = mod_t'(1 % prime);
    sq = mod_t'(b % prime);
    while (e != 0) begin
      if (e[0]) acc = mulp(acc, sq);
      e = e >> 1;
      sq = mulp(sq, sq);
    end
    return acc;
  endfunction

  function automatic answer_t binom_mod(query_t q);
    answer_t r;
    mod_t v;
    r = '0;
    if (q.k > q.n) begin
      r.bad = 1'b1;
      return r;
    end
    if (prime < 2) return r;
    while (fact_cnt <= int'(q.n)) begin
      fact_tab[fact_cnt] = mulp(fact_tab[fact_cnt-1], mod_t'(fact_cnt % prime));
      fact_cnt++;
    end
    v = mod_t'(fact_tab[q.n] % prime);
    v = mulp(v, powp(fact_tab[q.k], prime - 2));
    v = mulp(v, powp(fact_tab[q.n - q.k], prime - 2));
    r.coef = v;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.n_total <= '0;
      in_ch.k_choose <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (drv_gap > 0) begin
      in_ch.valid <= 1'b0;
      drv_gap <= drv_gap - 1;
    end else if (pending_q.size() > 0) begin
      query_t q;
      q = pending_q.pop_front();
      coef_q.push_back(binom_mod(q));
      in_ch.valid <= 1'b1;
      in_ch.n_total <= q.n;
      in_ch.k_choose <= q.k;
      drv_gap <= $urandom_range(0, 13);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (coef_q.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          answer_t e;
          e = coef_q.pop_front();
          if (out_ch.coefficient !== e.coef) begin
            $error("coefficient exp %0d got %0d", e.coef, out_ch.coefficient);
            errors++;
          end
          if (out_ch.bad_args !== e.bad) begin
            $error("bad_args exp %0d got %0d", e.bad, out_ch.bad_args);
            errors++;
          end
        end
        mon_gap <= $urandom_range(0, 13);
        out_ch.ready <= 1'b0;
      end else if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (pending_q.size() > 0 || coef_q.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_prime(mod_t p);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    prime = p;
    fact_cnt = 1;
    @(posedge clk);
  endtask

  task automatic add_query(int n, int k);
    query_t q;
    q.n = idx_t'(n);
    q.k = idx_t'(k);
    pending_q.push_back(q);
  endtask

  task automatic random_phase(int count, int nmax);
    int n;
    repeat (count) begin
      n = $urandom_range(0, nmax);
      if ($urandom_range(0, 9) == 0) add_query(n, $urandom_range(0, 1023));
      else add_query(n, $urandom_range(0, n));
    end
  endtask

  initial begin
    mod_t plist[6];
    plist = '{31'd2, 31'd3, 31'd13, 31'd1009, 31'd65521, 31'h7FFF_FFFF};
    prime = MOD_RESET;
    fact_cnt = 1;
    fact_tab[0] = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    add_query(0, 0);
    add_query(5, 2);
    add_query(1023, 0);
    add_query(1023, 1023);
    add_query(1023, 511);
    add_query(3, 4);
    add_query(0, 1023);
    add_query(682, 341);
    wait_idle();
    set_prime(31'd0);
    add_query(10, 3);
    add_query(2, 5);
    wait_idle();
    set_prime(31'd1);
    add_query(7, 7);
    wait_idle();
    foreach (plist[i]) begin
      set_prime(plist[i]);
      add_query(12, 6);
      add_query(1023, 1000);
      add_query(4, 9);
      random_phase(40, (i % 2) ? 1023 : 60);
      wait_idle();
    end
    set_prime(31'd1000);
    random_phase(20, 200);
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("[binomial_coefficient_mod_prime] OK");
    else $display("[binomial_coefficient_mod_prime] ERROR");
    $finish;
  end

  initial begin
    #600ms;
    $display("[binomial_coefficient_mod_prime] ERROR");
    $finish;
  end
endmodule
